[rtl/core/tdbe_pkg.sv]
// Shared types and constants for the timed debouncer with edge flags.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tdbe_pkg;

  // Width of the hold time register.
  localparam int unsigned HOLD_W = 26;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'b1;

  // Debounce modes. The low bit delays rising changes and the high bit
  // delays falling changes.
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_RISE = 2'd1,
    MODE_FALL = 2'd2,
    MODE_BOTH = 2'd3
  } debounce_mode_e;

  // One result item.
  typedef struct packed {
    logic level;
    logic rose;
    logic fell;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/tdbe_step.sv]
// Next-state and result logic for one sample of the debouncer.
// Depends on tdbe_pkg for the mode type, the hold width and the result struct.
`default_nettype none

module tdbe_step #(
  parameter int unsigned TIME_BITS = 48
) (
  input  tdbe_pkg::debounce_mode_e mode_i,
  input  logic [tdbe_pkg::HOLD_W-1:0] hold_i,
  input  logic                   sample_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  logic                   stable_i,
  input  logic [TIME_BITS-1:0]   window_i,
  output logic                   stable_o,
  output logic [TIME_BITS-1:0]   window_o,
  output tdbe_pkg::result_t      result_o
);
  import tdbe_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_met;

  // The subtraction wraps with the timestamp.
  assign elapsed  = now_i - window_i;
  assign hold_met = CMP_W'(elapsed) >= CMP_W'(hold_i);

  always_comb begin
    stable_o = stable_i;
    window_o = window_i;
    unique case (mode_i)
      MODE_NONE: begin
        stable_o = sample_i;
      end
      MODE_RISE: begin
        if (!stable_i && sample_i) begin
          if (hold_met) stable_o = 1'b1;
        end else if (!sample_i) begin
          window_o = now_i;
          stable_o = 1'b0;
        end
      end
      MODE_FALL: begin
        if (stable_i && !sample_i) begin
          if (hold_met) stable_o = 1'b0;
        end else if (sample_i) begin
          window_o = now_i;
          stable_o = 1'b1;
        end
      end
      MODE_BOTH: begin
        if (stable_i != sample_i) begin
          if (hold_met) stable_o = sample_i;
        end else begin
          window_o = now_i;
        end
      end
      default: begin
        stable_o = stable_i;
      end
    endcase
  end

  // The prior debounced level always equals the stored level before this
  // sample, so the edge flags compare against it.
  assign result_o.level = stable_o;
  assign result_o.rose  = !stable_i && stable_o;
  assign result_o.fell  = stable_i && !stable_o;

endmodule

`default_nettype wire

[rtl/core/timed_debouncer_with_edges_unit.sv]
// Top level of the timed switch debouncer with rising and falling edge flags.
// Depends on tdbe_pkg and instantiates tdbe_step.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+-----------------------------
//   in       | sink      | in_valid_i / in_ready_o   | sample_level_i, now_us_i
//   out      | source    | out_valid_o / out_ready_i | level_out_o, rose_o, fell_o
//   cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An input transfer loads the input register; when the compute stage advances, the
// debounce logic loads the result register and the state, so the result is then valid
// and can be taken. One item per cycle is sustained while results are taken. With
// the result register full and not taken, the compute stage holds and an empty input
// register takes one more item before ready drops.
// Reset clears the debounced state and valid flags but no data; cfg always accepts.
`default_nettype none

module timed_debouncer_with_edges_unit #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tdbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tdbe_pkg::HOLD_W-1:0]      cfg_data_i,
  // Sample channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             sample_level_i,
  input  logic [TIME_BITS-1:0]             now_us_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             level_out_o,
  output logic                             rose_o,
  output logic                             fell_o
);
  import tdbe_pkg::*;

  // Configuration registers.
  debounce_mode_e     mode_q;
  logic [HOLD_W-1:0]  hold_q;

  // Input register.
  logic                 in_valid_q;
  logic                 sample_q;
  logic [TIME_BITS-1:0] now_q;

  // Debounce state.
  logic                 stable_q, stable_d;
  logic                 prior_q;
  logic [TIME_BITS-1:0] window_q, window_d;

  // Result register.
  logic    out_valid_q;
  result_t result_q, result_d;

  logic advance;
  logic fire;

  // The compute stage moves when the result register is empty or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      hold_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE: mode_q <= debounce_mode_e'(cfg_data_i[1:0]);
        CFG_HOLD: hold_q <= cfg_data_i;
        default:  hold_q <= hold_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_level_i;
      now_q    <= now_us_i;
    end
  end

  tdbe_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .mode_i   (mode_q),
    .hold_i   (hold_q),
    .sample_i (sample_q),
    .now_i    (now_q),
    .stable_i (stable_q),
    .window_i (window_q),
    .stable_o (stable_d),
    .window_o (window_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      prior_q  <= 1'b0;
      window_q <= '0;
    end else if (fire) begin
      stable_q <= stable_d;
      prior_q  <= stable_d;
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = result_q.level;
  assign rose_o      = result_q.rose;
  assign fell_o      = result_q.fell;

  // The stored prior level tracks the debounced level after every sample.
  a_prior_tracks_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prior_q == stable_q)
    else $error("prior level diverged from debounced level");

  // At most one edge flag, and each agrees with the reported level.
  a_edge_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rose_o && fell_o) && (!rose_o || level_out_o)
                    && (!fell_o || !level_out_o))
    else $error("edge flags inconsistent with level");

  // In passthrough the debounced level follows the sample directly.
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mode_q == MODE_NONE |=> stable_q == $past(sample_q))
    else $error("passthrough level mismatch");

  // A stalled result stays put until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_q))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
